// ===== design/dryer_heater_timer_controller_unit_macros.svh =====
// Assertion shorthands used by the verification checker of the dryer controller.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef DRYER_HEATER_TIMER_CONTROLLER_UNIT_MACROS_SVH
`define DRYER_HEATER_TIMER_CONTROLLER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DHTC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DHTC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/dhtc_pkg.sv =====
`default_nettype none

package dhtc_pkg;

  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 10;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 56;

  // Reset values of the configuration registers.
  localparam logic [9:0] TPS_RST       = 10'd100;
  localparam logic [7:0] TEMP_MIN_RST  = 8'd30;
  localparam logic [7:0] TEMP_MAX_RST  = 8'd90;
  localparam logic [4:0] TEMP_STEP_RST = 5'd5;
  localparam logic [5:0] HOURS_MIN_RST = 6'd1;
  localparam logic [5:0] HOURS_MAX_RST = 6'd24;
  localparam logic [4:0] HYST_RST      = 5'd5;
  localparam logic [5:0] BEEP_RST      = 6'd10;

  localparam logic [5:0] SEC_LAST  = 6'd59;
  localparam logic [5:0] MIN_LAST  = 6'd59;
  localparam logic [7:0] HOURS_SAT = 8'd255;

  typedef enum logic [1:0] {
    ST_STOP   = 2'd0,
    ST_WORK   = 2'd1,
    ST_FINISH = 2'd2
  } run_state_t;

  typedef enum logic [2:0] {
    CODE_NONE = 3'd0,
    CODE_UP   = 3'd1,
    CODE_DOWN = 3'd2,
    CODE_BOTH = 3'd3,
    CODE_MODE = 3'd4,
    CODE_RUN  = 3'd5
  } btn_code_t;

  typedef enum logic [2:0] {
    CFG_TICKS_PER_SECOND  = 3'd0,
    CFG_TEMP_MIN          = 3'd1,
    CFG_TEMP_MAX          = 3'd2,
    CFG_TEMP_STEP         = 3'd3,
    CFG_HOURS_MIN         = 3'd4,
    CFG_HOURS_MAX         = 3'd5,
    CFG_HYSTERESIS_MARGIN = 3'd6,
    CFG_BEEP_INTERVAL     = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [9:0] ticks_per_second;
    logic [7:0] temp_min;
    logic [7:0] temp_max;
    logic [4:0] temp_step;
    logic [5:0] hours_min;
    logic [5:0] hours_max;
    logic [4:0] hysteresis_margin;
    logic [5:0] beep_interval;
  } cfg_t;

  typedef struct packed {
    logic       up_level;
    logic       down_level;
    logic       select_level;
    logic       start_level;
    logic [8:0] temperature_c;
  } in_item_t;

  typedef struct packed {
    logic       heater_on;
    logic       activity_led;
    logic       beeper_on;
    logic [1:0] run_state;
    logic       setting_select;
    logic [5:0] target_hours;
    logic [7:0] target_temp;
    logic [7:0] clock_hours;
    logic [5:0] clock_minutes;
    logic [5:0] clock_seconds;
    logic [8:0] held_temp;
  } result_t;

endpackage

`default_nettype wire

// ===== design/dhtc_cfg_regs.sv =====
`default_nettype none

module dhtc_cfg_regs (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               cfg_valid,
  output logic                              cfg_ready,
  input  wire  [dhtc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire  [dhtc_pkg::CFG_DATA_W-1:0]   cfg_data,
  output dhtc_pkg::cfg_t                    cfg
);
  import dhtc_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_TICKS_PER_SECOND:  cfg_nxt.ticks_per_second  = cfg_data;
        CFG_TEMP_MIN:          cfg_nxt.temp_min          = cfg_data[7:0];
        CFG_TEMP_MAX:          cfg_nxt.temp_max          = cfg_data[7:0];
        CFG_TEMP_STEP:         cfg_nxt.temp_step         = cfg_data[4:0];
        CFG_HOURS_MIN:         cfg_nxt.hours_min         = cfg_data[5:0];
        CFG_HOURS_MAX:         cfg_nxt.hours_max         = cfg_data[5:0];
        CFG_HYSTERESIS_MARGIN: cfg_nxt.hysteresis_margin = cfg_data[4:0];
        CFG_BEEP_INTERVAL:     cfg_nxt.beep_interval     = cfg_data[5:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ticks_per_second  <= TPS_RST;
      cfg_r.temp_min          <= TEMP_MIN_RST;
      cfg_r.temp_max          <= TEMP_MAX_RST;
      cfg_r.temp_step         <= TEMP_STEP_RST;
      cfg_r.hours_min         <= HOURS_MIN_RST;
      cfg_r.hours_max         <= HOURS_MAX_RST;
      cfg_r.hysteresis_margin <= HYST_RST;
      cfg_r.beep_interval     <= BEEP_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/dhtc_in_reg.sv =====
`default_nettype none

module dhtc_in_reg (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_tvalid,
  output logic                              in_tready,
  input  wire  [dhtc_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  wire                               take,
  output logic                              item_valid,
  output dhtc_pkg::in_item_t                item
);
  import dhtc_pkg::*;

  logic     valid_r;
  logic     valid_nxt;
  in_item_t item_r;
  logic     load;

  // The register frees up in the same cycle its item moves on.
  assign in_tready  = !valid_r || take;
  assign load       = in_tvalid && in_tready;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r.up_level      <= in_tdata[0];
      item_r.down_level    <= in_tdata[1];
      item_r.select_level  <= in_tdata[2];
      item_r.start_level   <= in_tdata[3];
      item_r.temperature_c <= in_tdata[12:4];
    end
  end

endmodule

`default_nettype wire

// ===== design/dhtc_core.sv =====
`default_nettype none

module dhtc_core (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      fire,
  input  wire dhtc_pkg::in_item_t  item,
  input  wire dhtc_pkg::cfg_t      cfg,
  output dhtc_pkg::result_t        res
);
  import dhtc_pkg::*;

  run_state_t mode_r, mode_nxt;
  btn_code_t  last_code_r, last_code_nxt;
  btn_code_t  code;
  logic       adj_r, adj_nxt;
  logic [5:0] hours_r, hours_nxt;
  logic [7:0] temp_r, temp_nxt;
  logic       heat_r, heat_nxt;
  logic [8:0] samp_r, samp_nxt;
  logic [5:0] wls_r, wls_nxt;
  logic [5:0] fls_r, fls_nxt;
  logic [5:0] beep_r, beep_nxt;
  logic       buzz_r, buzz_nxt;
  logic [9:0] div_r, div_nxt;
  logic [5:0] sec_r, sec_nxt;
  logic [5:0] min_r, min_nxt;
  logic [7:0] hr_r, hr_nxt;
  logic       led;
  logic       heater;
  logic [8:0] temp_up;
  logic [8:0] temp_dn;
  logic [9:0] samp_plus_margin;
  logic [10:0] div_inc;

  always_comb begin
    if (item.up_level && item.down_level) begin
      code = CODE_BOTH;
    end else if (item.up_level) begin
      code = CODE_UP;
    end else if (item.down_level) begin
      code = CODE_DOWN;
    end else if (item.start_level) begin
      code = CODE_RUN;
    end else if (item.select_level) begin
      code = CODE_MODE;
    end else begin
      code = CODE_NONE;
    end
  end

  assign temp_up = {1'b0, temp_r} + {4'd0, cfg.temp_step};
  assign temp_dn = {1'b0, temp_r} - {4'd0, cfg.temp_step};

  always_comb begin
    mode_nxt         = mode_r;
    last_code_nxt    = last_code_r;
    adj_nxt          = adj_r;
    hours_nxt        = hours_r;
    temp_nxt         = temp_r;
    heat_nxt         = heat_r;
    samp_nxt         = samp_r;
    wls_nxt          = wls_r;
    fls_nxt          = fls_r;
    beep_nxt         = beep_r;
    buzz_nxt         = buzz_r;
    sec_nxt          = sec_r;
    min_nxt          = min_r;
    hr_nxt           = hr_r;
    led              = 1'b0;
    heater           = 1'b0;
    samp_plus_margin = '0;

    // Buttons act once per change of code.
    if (code == CODE_NONE) begin
      last_code_nxt = CODE_NONE;
    end else if (code != last_code_r) begin
      last_code_nxt = code;
      case (code)
        CODE_RUN:  mode_nxt = (mode_r == ST_WORK) ? ST_STOP : ST_WORK;
        CODE_MODE: adj_nxt = ~adj_r;
        CODE_UP: begin
          if (!adj_r) begin
            if (hours_r < cfg.hours_max) hours_nxt = hours_r + 6'd1;
          end else if (temp_r < cfg.temp_max) begin
            temp_nxt = (temp_up > {1'b0, cfg.temp_max}) ? cfg.temp_max : temp_up[7:0];
          end
        end
        CODE_DOWN: begin
          if (!adj_r) begin
            if (hours_r > cfg.hours_min) hours_nxt = hours_r - 6'd1;
          end else if (temp_r > cfg.temp_min) begin
            // A step below zero also lands on the lower limit.
            if (({3'd0, cfg.temp_step} > temp_r) || (temp_dn[7:0] < cfg.temp_min)) begin
              temp_nxt = cfg.temp_min;
            end else begin
              temp_nxt = temp_dn[7:0];
            end
          end
        end
        default: ;
      endcase
    end

    unique case (mode_nxt)
      ST_WORK: begin
        if (wls_r != sec_r) begin
          wls_nxt  = sec_r;
          samp_nxt = item.temperature_c;
          led      = 1'b1;
        end
        if (hr_r >= {2'd0, hours_nxt}) begin
          mode_nxt = ST_FINISH;
          sec_nxt  = '0;
          min_nxt  = '0;
          hr_nxt   = '0;
        end
        // The sample either holds or takes the new temperature; both fit in ten bits
        // with the margin.
        samp_plus_margin = {1'b0, samp_nxt} + {5'd0, cfg.hysteresis_margin};
        if (samp_nxt >= {1'b0, temp_nxt}) begin
          heat_nxt = 1'b0;
        end else if (!heat_r && (samp_plus_margin < {2'd0, temp_nxt})) begin
          heat_nxt = 1'b1;
        end
        heater = heat_nxt;
      end
      ST_FINISH: begin
        led     = 1'b1;
        adj_nxt = 1'b0;
        if (fls_r != sec_r) begin
          fls_nxt = sec_r;
          if (beep_r < cfg.beep_interval) begin
            beep_nxt = beep_r + 6'd1;
          end else begin
            beep_nxt = '0;
            buzz_nxt = 1'b1;
          end
        end else begin
          buzz_nxt = 1'b0;
        end
      end
      default: begin
        mode_nxt  = ST_STOP;
        buzz_nxt  = 1'b0;
        heat_nxt  = 1'b0;
        hours_nxt = cfg.hours_min;
        temp_nxt  = cfg.temp_min;
        adj_nxt   = 1'b0;
        sec_nxt   = '0;
        min_nxt   = '0;
        hr_nxt    = '0;
      end
    endcase

    // Clock advance runs after the handler, on the possibly cleared count.
    if (div_inc < {1'b0, cfg.ticks_per_second}) begin
      div_nxt = div_inc[9:0];
    end else begin
      div_nxt = '0;
      if (sec_nxt < SEC_LAST) begin
        sec_nxt = sec_nxt + 6'd1;
      end else begin
        sec_nxt = '0;
        if (min_nxt < MIN_LAST) begin
          min_nxt = min_nxt + 6'd1;
        end else begin
          min_nxt = '0;
          if (hr_nxt != HOURS_SAT) hr_nxt = hr_nxt + 8'd1;
        end
      end
    end
  end

  assign div_inc = {1'b0, div_r} + 11'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= ST_STOP;
      last_code_r <= CODE_NONE;
      adj_r       <= 1'b0;
      hours_r     <= HOURS_MIN_RST;
      temp_r      <= TEMP_MIN_RST;
      heat_r      <= 1'b0;
      samp_r      <= '0;
      wls_r       <= '0;
      fls_r       <= '0;
      beep_r      <= '0;
      buzz_r      <= 1'b0;
      div_r       <= '0;
      sec_r       <= '0;
      min_r       <= '0;
      hr_r        <= '0;
    end else if (fire) begin
      mode_r      <= mode_nxt;
      last_code_r <= last_code_nxt;
      adj_r       <= adj_nxt;
      hours_r     <= hours_nxt;
      temp_r      <= temp_nxt;
      heat_r      <= heat_nxt;
      samp_r      <= samp_nxt;
      wls_r       <= wls_nxt;
      fls_r       <= fls_nxt;
      beep_r      <= beep_nxt;
      buzz_r      <= buzz_nxt;
      div_r       <= div_nxt;
      sec_r       <= sec_nxt;
      min_r       <= min_nxt;
      hr_r        <= hr_nxt;
    end
  end

  always_comb begin
    res.heater_on      = heater;
    res.activity_led   = led;
    res.beeper_on      = buzz_nxt;
    res.run_state      = mode_nxt;
    res.setting_select = adj_nxt;
    res.target_hours   = hours_nxt;
    res.target_temp    = temp_nxt;
    res.clock_hours    = hr_nxt;
    res.clock_minutes  = min_nxt;
    res.clock_seconds  = sec_nxt;
    res.held_temp      = samp_nxt;
  end

endmodule

`default_nettype wire

// ===== design/dhtc_out_reg.sv =====
`default_nettype none

module dhtc_out_reg (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               load,
  input  wire dhtc_pkg::result_t            res,
  output logic                              out_tvalid,
  input  wire                               out_tready,
  output logic [dhtc_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import dhtc_pkg::*;

  logic    valid_r;
  logic    valid_nxt;
  result_t res_r;

  assign out_tvalid = valid_r;
  assign out_tdata  = {7'd0,
                       res_r.held_temp,
                       res_r.clock_seconds,
                       res_r.clock_minutes,
                       res_r.clock_hours,
                       res_r.target_temp,
                       res_r.target_hours,
                       res_r.setting_select,
                       res_r.run_state,
                       res_r.beeper_on,
                       res_r.activity_led,
                       res_r.heater_on};

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

endmodule

`default_nettype wire

// ===== design/dryer_heater_timer_controller_unit.sv =====
// Dryer heater timer controller. Each input item is one timer tick with four button
// levels and a temperature; each accepted item yields exactly one result item with the
// heater, LED and buzzer drives, run state, settings, elapsed clock and held temperature.
// An item passes an input register, one combinational pass through the controller, and
// the result register, which loads when it is empty or being drained; a new item can be
// accepted every cycle while the output drains, and while a result waits, one more item
// can still be taken into the input register. Throughput is one item per clock,
// limited only by out_tready. Configuration writes are accepted every cycle (cfg_ready
// is tied high) and must only be issued while no item is in flight.
`default_nettype none

module dryer_heater_timer_controller_unit (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_tvalid,
  output logic                              in_tready,
  // up_level[0], down_level[1], select_level[2], start_level[3], temperature_c[12:4]
  input  wire  [dhtc_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                              out_tvalid,
  input  wire                               out_tready,
  // heater_on[0], activity_led[1], beeper_on[2], run_state[4:3], setting_select[5],
  // target_hours[11:6], target_temp[19:12], clock_hours[27:20], clock_minutes[33:28],
  // clock_seconds[39:34], held_temp[48:40]
  output logic [dhtc_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input  wire                               cfg_valid,
  output logic                              cfg_ready,
  input  wire  [dhtc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire  [dhtc_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import dhtc_pkg::*;

  cfg_t     cfg;
  in_item_t item;
  logic     item_valid;
  result_t  res;
  logic     fire;

  // The held item moves on when the result register is empty or being drained.
  assign fire = item_valid && (!out_tvalid || out_tready);

  dhtc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dhtc_in_reg u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .take       (fire),
    .item_valid (item_valid),
    .item       (item)
  );

  dhtc_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (item),
    .cfg   (cfg),
    .res   (res)
  );

  dhtc_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (fire),
    .res        (res),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire

// ===== design/dhtc_checker.sv =====
`default_nettype none
`include "dryer_heater_timer_controller_unit_macros.svh"

module dhtc_checker (
  input wire                               clk,
  input wire                               rst_n,
  input wire                               out_tvalid,
  input wire                               out_tready,
  input wire [dhtc_pkg::OUT_TDATA_W-1:0]   out_tdata
);
  import dhtc_pkg::*;

  logic [1:0] run_st;
  logic       stalled;
  logic       stop_item;
  logic       stop_idle;
  logic       clock_ok;
  logic       heat_ok;

  assign run_st    = out_tdata[4:3];
  assign stalled   = out_tvalid && !out_tready;
  assign stop_item = out_tvalid && (run_st == ST_STOP);
  assign stop_idle = !out_tdata[0] && !out_tdata[5] && (out_tdata[27:20] == 8'd0) &&
                     (out_tdata[33:28] == 6'd0);
  assign clock_ok  = (out_tdata[39:34] <= SEC_LAST) && (out_tdata[33:28] <= MIN_LAST);
  // The heater may still be on in the item where drying turns into finished.
  assign heat_ok   = (run_st == ST_WORK) || (run_st == ST_FINISH);

  `DHTC_ASSERT_NEXT(a_out_hold, stalled, out_tvalid && $stable(out_tdata), "stalled item changed")
  `DHTC_ASSERT_IMPL(a_stop_clear, stop_item, stop_idle, "stopped item shows activity")
  `DHTC_ASSERT_IMPL(a_clock_range, out_tvalid, clock_ok, "clock seconds or minutes out of range")
  `DHTC_ASSERT_IMPL(a_heater_run, out_tvalid && out_tdata[0], heat_ok, "heater driven while stopped")

endmodule

bind dryer_heater_timer_controller_unit dhtc_checker u_dhtc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

// ===== tb/dryer_status_checker.sv =====
`timescale 1ns / 100ps

module dryer_status_checker (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_tvalid,
  input  wire                                in_tready,
  input  wire [dhtc_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  wire                                out_tvalid,
  input  wire                                out_tready,
  input  wire [dhtc_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  wire                                cfg_valid,
  input  wire                                cfg_ready,
  input  wire [dhtc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire [dhtc_pkg::CFG_DATA_W-1:0]     cfg_data,
  output int                                 mismatches,
  output int                                 pending
);
  import dhtc_pkg::*;

  cfg_t       regs;
  run_state_t phase;
  btn_code_t  prev_code;
  logic [9:0] div_cnt;
  logic [5:0] secs, mins, work_sec, fin_sec, beeps, hrs_target;
  logic [7:0] hrs, temp_target;
  logic [8:0] held;
  logic       sel_temp, heat, buzz;
  result_t    status_q[$];
  int         errs = 0;

  task check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      errs++;
      if (errs <= 10) $display("%t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // Applies one tick to the mirrored controller state and returns the status it should show.
  task advance_dryer(input in_item_t tick, output result_t res);
    btn_code_t code;
    int        sum;
    logic      heat_now, led_now;
    heat_now = 1'b0;
    led_now  = 1'b0;

    if (tick.up_level && tick.down_level) code = CODE_BOTH;
    else if (tick.up_level) code = CODE_UP;
    else if (tick.down_level) code = CODE_DOWN;
    else if (tick.start_level) code = CODE_RUN;
    else if (tick.select_level) code = CODE_MODE;
    else code = CODE_NONE;

    // A button acts only on a change of code; releasing everything forgets the code.
    if (code == CODE_NONE) begin
      prev_code = CODE_NONE;
    end else if (code != prev_code) begin
      prev_code = code;
      case (code)
        CODE_RUN: begin
          phase = (phase == ST_WORK) ? ST_STOP : ST_WORK;
        end
        CODE_MODE: begin
          sel_temp = !sel_temp;
        end
        CODE_UP: begin
          if (!sel_temp) begin
            if (hrs_target < regs.hours_max) hrs_target = hrs_target + 6'd1;
          end else if (temp_target < regs.temp_max) begin
            sum = int'(temp_target) + int'(regs.temp_step);
            temp_target = (sum > int'(regs.temp_max)) ? regs.temp_max : 8'(sum);
          end
        end
        CODE_DOWN: begin
          if (!sel_temp) begin
            if (hrs_target > regs.hours_min) hrs_target = hrs_target - 6'd1;
          end else if (temp_target > regs.temp_min) begin
            sum = int'(temp_target) - int'(regs.temp_step);
            temp_target = (sum < int'(regs.temp_min)) ? regs.temp_min : 8'(sum);
          end
        end
        default: begin
        end
      endcase
    end

    case (phase)
      ST_WORK: begin
        if (work_sec != secs) begin
          work_sec = secs;
          held     = tick.temperature_c;
          led_now  = 1'b1;
        end
        if (hrs >= hrs_target) begin
          phase = ST_FINISH;
          secs  = '0;
          mins  = '0;
          hrs   = '0;
        end
        // The restart threshold may go below zero, so compare as signed integers.
        if (held >= temp_target) heat = 1'b0;
        else if (!heat && int'(held) < int'(temp_target) - int'(regs.hysteresis_margin))
          heat = 1'b1;
        heat_now = heat;
      end
      ST_FINISH: begin
        led_now  = 1'b1;
        sel_temp = 1'b0;
        if (fin_sec != secs) begin
          fin_sec = secs;
          if (beeps < regs.beep_interval) begin
            beeps = beeps + 6'd1;
          end else begin
            beeps = '0;
            buzz  = 1'b1;
          end
        end else begin
          buzz = 1'b0;
        end
      end
      default: begin
        phase       = ST_STOP;
        buzz        = 1'b0;
        heat        = 1'b0;
        hrs_target  = regs.hours_min;
        temp_target = regs.temp_min;
        sel_temp    = 1'b0;
        secs        = '0;
        mins        = '0;
        hrs         = '0;
      end
    endcase

    // A tick count of zero behaves like one: the divider wraps on every tick.
    if (int'(div_cnt) + 1 < int'(regs.ticks_per_second)) begin
      div_cnt = div_cnt + 10'd1;
    end else begin
      div_cnt = '0;
      if (secs < SEC_LAST) begin
        secs = secs + 6'd1;
      end else begin
        secs = '0;
        if (mins < MIN_LAST) begin
          mins = mins + 6'd1;
        end else begin
          mins = '0;
          if (hrs < HOURS_SAT) hrs = hrs + 8'd1;
        end
      end
    end

    res.heater_on      = heat_now;
    res.activity_led   = led_now;
    res.beeper_on      = buzz;
    res.run_state      = phase;
    res.setting_select = sel_temp;
    res.target_hours   = hrs_target;
    res.target_temp    = temp_target;
    res.clock_hours    = hrs;
    res.clock_minutes  = mins;
    res.clock_seconds  = secs;
    res.held_temp      = held;
  endtask

  always @(posedge clk) begin : watch
    result_t  want, got;
    in_item_t tick;
    if (!rst_n) begin
      regs.ticks_per_second  = TPS_RST;
      regs.temp_min          = TEMP_MIN_RST;
      regs.temp_max          = TEMP_MAX_RST;
      regs.temp_step         = TEMP_STEP_RST;
      regs.hours_min         = HOURS_MIN_RST;
      regs.hours_max         = HOURS_MAX_RST;
      regs.hysteresis_margin = HYST_RST;
      regs.beep_interval     = BEEP_RST;
      phase       = ST_STOP;
      prev_code   = CODE_NONE;
      div_cnt     = '0;
      secs        = '0;
      mins        = '0;
      hrs         = '0;
      work_sec    = '0;
      fin_sec     = '0;
      beeps       = '0;
      hrs_target  = HOURS_MIN_RST;
      temp_target = TEMP_MIN_RST;
      held        = '0;
      sel_temp    = 1'b0;
      heat        = 1'b0;
      buzz        = 1'b0;
      status_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got.heater_on      = out_tdata[0];
        got.activity_led   = out_tdata[1];
        got.beeper_on      = out_tdata[2];
        got.run_state      = out_tdata[4:3];
        got.setting_select = out_tdata[5];
        got.target_hours   = out_tdata[11:6];
        got.target_temp    = out_tdata[19:12];
        got.clock_hours    = out_tdata[27:20];
        got.clock_minutes  = out_tdata[33:28];
        got.clock_seconds  = out_tdata[39:34];
        got.held_temp      = out_tdata[48:40];
        if (status_q.size() == 0) begin
          errs++;
          if (errs <= 10) $display("%t: status item arrived with none expected", $time);
        end else begin
          want = status_q.pop_front();
          check_field("heater_on", want.heater_on, got.heater_on);
          check_field("activity_led", want.activity_led, got.activity_led);
          check_field("beeper_on", want.beeper_on, got.beeper_on);
          check_field("run_state", want.run_state, got.run_state);
          check_field("setting_select", want.setting_select, got.setting_select);
          check_field("target_hours", want.target_hours, got.target_hours);
          check_field("target_temp", want.target_temp, got.target_temp);
          check_field("clock_hours", want.clock_hours, got.clock_hours);
          check_field("clock_minutes", want.clock_minutes, got.clock_minutes);
          check_field("clock_seconds", want.clock_seconds, got.clock_seconds);
          check_field("held_temp", want.held_temp, got.held_temp);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_TICKS_PER_SECOND:  regs.ticks_per_second  = cfg_data[9:0];
          CFG_TEMP_MIN:          regs.temp_min          = cfg_data[7:0];
          CFG_TEMP_MAX:          regs.temp_max          = cfg_data[7:0];
          CFG_TEMP_STEP:         regs.temp_step         = cfg_data[4:0];
          CFG_HOURS_MIN:         regs.hours_min         = cfg_data[5:0];
          CFG_HOURS_MAX:         regs.hours_max         = cfg_data[5:0];
          CFG_HYSTERESIS_MARGIN: regs.hysteresis_margin = cfg_data[4:0];
          CFG_BEEP_INTERVAL:     regs.beep_interval     = cfg_data[5:0];
          default: begin
          end
        endcase
      end
      if (in_tvalid && in_tready) begin
        tick.up_level      = in_tdata[0];
        tick.down_level    = in_tdata[1];
        tick.select_level  = in_tdata[2];
        tick.start_level   = in_tdata[3];
        tick.temperature_c = in_tdata[12:4];
        advance_dryer(tick, want);
        status_q.push_back(want);
      end
    end
    mismatches <= errs;
    pending    <= status_q.size();
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import dhtc_pkg::*;

  logic                   clk, rst_n;
  logic                   in_tvalid, out_tready, cfg_valid;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  wire                    in_tready, out_tvalid, cfg_ready;
  wire [OUT_TDATA_W-1:0]  out_tdata;
  int                     mismatches, pending;
  bit                     calm, soak;
  int                     sent, settings, recv_stall;
  logic [8:0]             temp_now;

  dryer_heater_timer_controller_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  dryer_status_checker u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("tb: errors");
    $finish;
  end

  // Mostly short gaps, a few long ones, and none at all during calm or soak stretches.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || soak) return 0;
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  initial begin
    forever begin
      repeat (200) @(posedge clk);
      calm <= ($urandom_range(0, 3) == 0);
    end
  end

  initial begin
    out_tready = 1'b0;
    recv_stall = 0;
    forever begin
      @(negedge clk);
      if (recv_stall > 0) begin
        out_tready <= 1'b0;
        recv_stall--;
      end else begin
        out_tready <= 1'b1;
        recv_stall = idle_len();
      end
    end
  end

  task send_tick(input logic up, dn, sel, run, input logic [8:0] temp);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, temp, run, sel, dn, up};
    do @(posedge clk); while (!in_tready);
    sent++;
  endtask

  // Holds the sender off until every status item in flight has come back.
  task settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task write_reg(input cfg_idx_t idx, input int value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= 10'(value);
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task load_settings(input int tps, tmin, tmax, tstep, hmin, hmax, hyst, beep);
    settle();
    write_reg(CFG_TICKS_PER_SECOND, tps);
    write_reg(CFG_TEMP_MIN, tmin);
    write_reg(CFG_TEMP_MAX, tmax);
    write_reg(CFG_TEMP_STEP, tstep);
    write_reg(CFG_HOURS_MIN, hmin);
    write_reg(CFG_HOURS_MAX, hmax);
    write_reg(CFG_HYSTERESIS_MARGIN, hyst);
    write_reg(CFG_BEEP_INTERVAL, beep);
    settings++;
  endtask

  // Button presses, if with_buttons is set, held for a few ticks with releases between them,
  // plus some noise; the temperature mostly drifts slowly so the heater crosses its thresholds.
  task random_ticks(input int count, input bit with_buttons);
    int         hold, r, t;
    logic [3:0] btn;
    hold = 0;
    btn  = 4'b0000;
    repeat (count) begin
      if (hold == 0) begin
        r = $urandom_range(0, 99);
        if (!with_buttons || r < 40) btn = 4'b0000;
        else if (r < 55) btn = 4'b0001;
        else if (r < 70) btn = 4'b0010;
        else if (r < 78) btn = 4'b0100;
        else if (r < 85) btn = 4'b1000;
        else if (r < 90) btn = 4'b0011;
        else btn = 4'($urandom_range(0, 15));
        hold = $urandom_range(1, 4);
      end
      hold--;
      r = $urandom_range(0, 99);
      if (r < 5) begin
        temp_now = 9'($urandom_range(0, 330));
      end else if (r < 15) begin
        temp_now = 9'($urandom_range(0, 160));
      end else begin
        t = int'(temp_now) + int'($urandom_range(0, 6)) - 3;
        if (t < 0) t = 0;
        if (t > 330) t = 330;
        temp_now = 9'(t);
      end
      send_tick(btn[0], btn[1], btn[2], btn[3], temp_now);
      if (with_buttons && $urandom_range(0, 99) == 0) settle();
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    temp_now  = 9'd60;
    sent      = 0;
    settings  = 1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Short walk through the button logic at the reset settings.
    send_tick(0, 0, 0, 0, 9'd0);
    send_tick(0, 0, 0, 0, 9'd330);
    send_tick(1, 0, 0, 0, 9'd25);   // up while stopped is overwritten
    send_tick(1, 1, 0, 0, 9'd25);   // up with down does nothing
    send_tick(0, 0, 0, 0, 9'd25);
    send_tick(0, 0, 1, 0, 9'd25);   // mode while stopped is overwritten
    send_tick(0, 0, 0, 0, 9'd25);
    send_tick(0, 0, 0, 1, 9'd25);   // start drying
    send_tick(0, 0, 0, 1, 9'd25);   // held run is not a new press
    send_tick(0, 0, 0, 0, 9'd10);
    send_tick(0, 0, 1, 0, 9'd10);   // select temperature
    send_tick(1, 0, 0, 0, 9'd10);
    send_tick(1, 0, 0, 0, 9'd10);
    send_tick(0, 1, 0, 0, 9'd200);
    send_tick(1, 1, 0, 0, 9'd200);
    send_tick(1, 0, 0, 0, 9'd200);
    send_tick(0, 0, 0, 0, 9'd255);
    send_tick(0, 0, 1, 0, 9'd256);  // back to hours
    send_tick(1, 0, 0, 0, 9'd256);
    send_tick(0, 0, 0, 0, 9'd300);
    send_tick(0, 0, 1, 1, 9'd330);  // run outranks mode: stop
    send_tick(1, 1, 1, 1, 9'd330);
    send_tick(0, 0, 0, 0, 9'd1);
    send_tick(0, 0, 0, 1, 9'd2);

    // Zero hour floor makes drying finish at once; low floor with wide margin keeps heat off.
    load_settings(1, 0, 150, 20, 0, 63, 31, 1);
    random_ticks(250, 1);
    // Inverted limits.
    load_settings(3, 150, 0, 1, 63, 1, 0, 63);
    random_ticks(200, 1);
    // Zero ticks per second.
    load_settings(0, 40, 120, 7, 0, 5, 3, 2);
    random_ticks(250, 1);
    load_settings(1000, 30, 90, 5, 1, 24, 5, 10);
    random_ticks(150, 1);
    repeat (2) begin
      load_settings($urandom_range(1, 4), $urandom_range(0, 150), $urandom_range(0, 150),
                    $urandom_range(1, 20), $urandom_range(1, 63), $urandom_range(1, 63),
                    $urandom_range(0, 31), $urandom_range(1, 63));
      random_ticks(200, 1);
    end

    // A back-to-back drying run at one tick per second, long enough for a minute rollover.
    load_settings(1, 40, 60, 3, 1, 2, 4, 4);
    soak = 1'b1;
    send_tick(0, 0, 0, 1, temp_now);
    send_tick(0, 0, 0, 0, temp_now);
    random_ticks(70, 0);
    send_tick(0, 0, 0, 1, temp_now);  // stop again
    send_tick(0, 0, 0, 0, temp_now);
    random_ticks(10, 0);
    soak = 1'b0;

    settle();
    repeat (8) @(negedge clk);
    $display("summary: %0d ticks over %0d register settings, minute rollover while drying",
             sent, settings);
    $display("summary: held and overlapping presses, drifting temperatures, stalls on both sides");
    if (mismatches == 0 && pending == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

// ===== dryer_heater_timer_controller_unit.f =====
+incdir+design
design/dhtc_pkg.sv
design/dhtc_cfg_regs.sv
design/dhtc_in_reg.sv
design/dhtc_core.sv
design/dhtc_out_reg.sv
design/dryer_heater_timer_controller_unit.sv
design/dhtc_checker.sv
tb/dryer_status_checker.sv
tb/tb.sv
